// ===== rtl/core/ncs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ncs_pkg
// Shared types and constants of the normalised conductance spectrum unit.
// ----------------------------------------------------------------------------
package ncs_pkg;

	localparam int VW       = 24;  // voltage and current code width
	localparam int SVW      = 25;  // shifted voltage width
	localparam int TOLW     = 23;  // tolerance register width
	localparam int RATIOW   = 32;  // Q16.16 ratio
	localparam int STW      = 2;
	localparam int MAGW     = 24;  // magnitude of a difference or code
	localparam int PRODW    = 48;  // |dI|*|Vs| and |dV|*|I|
	localparam int FRACW    = 16;
	localparam int DIV_STEPS = 33; // quotient bits below the overflow limit
	localparam int DSTEPW   = $clog2(DIV_STEPS);

	localparam logic [STW-1:0] ST_OK   = 2'd0;
	localparam logic [STW-1:0] ST_SAT  = 2'd1;
	localparam logic [STW-1:0] ST_DIV0 = 2'd2;

	localparam logic [TOLW-1:0] TOL_RESET = 23'd1;

	typedef struct packed {
		logic load;      // store the accepted item
		logic clear;     // end of curve
		logic idx_clr;
		logic idx_inc;
		logic latch;     // take read data into the current/previous registers
		logic mark;      // note the index as the last kept point
		logic mul;
		logic div_init;
		logic div_step;
		logic out_load;
	} ncs_cmd_t;

	typedef struct packed {
		logic keep;      // point just read passes both tolerance checks
		logic idx_zero;
		logic idx_end;
		logic div_last;
		logic out_busy;
	} ncs_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/ncs_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ncs_sample_if / ncs_result_if
// Valid/ready channels for curve points and conductance results.
// ----------------------------------------------------------------------------
interface ncs_sample_if;
	import ncs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic signed [VW-1:0]  voltage_sample;
	logic signed [VW-1:0]  current_sample;
	logic                  last_point;

	modport source (output valid, voltage_sample, current_sample, last_point, input ready);
	modport sink   (input valid, voltage_sample, current_sample, last_point, output ready);
endinterface

interface ncs_result_if;
	import ncs_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [SVW-1:0]    shifted_voltage;
	logic signed [RATIOW-1:0] conductance_ratio;
	logic [STW-1:0]           result_status;
	logic                     last_result;

	modport source (output valid, shifted_voltage, conductance_ratio, result_status,
		last_result, input ready);
	modport sink   (input valid, shifted_voltage, conductance_ratio, result_status,
		last_result, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ncs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ncs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ncs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/ncs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ncs_ctrl
// Sequencer: loading, keep scan, per-point multiply and serial divide.
// ----------------------------------------------------------------------------
module ncs_ctrl
	import ncs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_last,
	output logic      in_ready,
	input  ncs_sts_t  sts,
	output ncs_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_LAT, S_RD, S_LAT, S_MUL, S_DIVI, S_DIV, S_FIN, S_DONE
	} state_t;

	state_t state_q;
	logic   kept;

	assign kept     = sts.keep && !sts.idx_zero;
	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:     if (in_valid && in_last) state_q <= S_SCAN_RD;
				S_SCAN_RD:  state_q <= S_SCAN_LAT;
				S_SCAN_LAT: state_q <= sts.idx_end ? S_RD : S_SCAN_RD;
				S_RD:       state_q <= S_LAT;
				S_LAT: begin
					if (kept)             state_q <= S_MUL;
					else if (sts.idx_end) state_q <= S_DONE;
					else                  state_q <= S_RD;
				end
				S_MUL:      state_q <= S_DIVI;
				S_DIVI:     state_q <= S_DIV;
				S_DIV:      if (sts.div_last) state_q <= S_FIN;
				S_FIN: begin
					if (!sts.out_busy) state_q <= sts.idx_end ? S_DONE : S_RD;
				end
				S_DONE:     state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && in_valid;
		cmd.idx_clr  = (state_q == S_IDLE) || (state_q == S_SCAN_LAT && sts.idx_end);
		cmd.idx_inc  = (state_q == S_SCAN_LAT && !sts.idx_end)
			|| (state_q == S_LAT && !kept && !sts.idx_end)
			|| (state_q == S_FIN && !sts.out_busy && !sts.idx_end);
		cmd.latch    = (state_q == S_SCAN_LAT) || (state_q == S_LAT);
		cmd.mark     = (state_q == S_SCAN_LAT) && kept;
		cmd.mul      = (state_q == S_MUL);
		cmd.div_init = (state_q == S_DIVI);
		cmd.div_step = (state_q == S_DIV);
		cmd.out_load = (state_q == S_FIN) && !sts.out_busy;
		cmd.clear    = (state_q == S_DONE);
	end

	// a result is only formed once the divider has run its last step
	a_fin_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |-> $past(state_q) == S_DIV || $past(state_q) == S_FIN)
		else $error("result stage entered without a finished division");

endmodule
`default_nettype wire

// ===== rtl/core/ncs_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ncs_dp
// Datapath: point stores, minimum tracking, keep test, products, restoring
// divider and the result register.
// ----------------------------------------------------------------------------
module ncs_dp
	import ncs_pkg::*;
#(
	parameter int MAX_POINTS = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  ncs_cmd_t                      cmd,
	output ncs_sts_t                      sts,
	input  wire logic                     cfg_we,
	input  wire logic [TOLW-1:0]          cfg_wdata,
	input  wire logic signed [VW-1:0]     voltage_sample,
	input  wire logic signed [VW-1:0]     current_sample,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [SVW-1:0]         shifted_voltage,
	output logic signed [RATIOW-1:0]      conductance_ratio,
	output logic [STW-1:0]                result_status,
	output logic                          last_result
);

	localparam int ADDR_W = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);

	logic [TOLW-1:0]       tol_q;
	logic [CNT_W-1:0]      count_q;
	logic [MAGW-1:0]       min_abs_q;
	logic signed [VW-1:0]  vmin_q;
	logic [ADDR_W-1:0]     idx_q;
	logic [ADDR_W-1:0]     last_keep_q;
	logic signed [VW-1:0]  cur_v_q, prev_v_q, cur_i_q, prev_i_q;
	logic [VW-1:0]         rd_v, rd_i;
	logic                  store_we;
	logic [MAGW-1:0]       abs_c;

	// keep test on the point just read against the previously latched one
	logic signed [SVW-1:0] rv_ext, rdv_diff;
	logic [MAGW-1:0]       abs_rv, abs_rdv;

	// per-point arithmetic on latched values
	logic signed [SVW-1:0] dv, di, vs, ci_ext;
	logic [MAGW-1:0]       abs_dv, abs_di, abs_vs, abs_ci;

	logic [PRODW-1:0]      num_q, den_q;
	logic                  neg_q, final_q;
	logic signed [SVW-1:0] vs_q;

	logic [PRODW-1:0]      rem_q;
	logic [DIV_STEPS-1:0]  dvd_q, quo_q;
	logic [DSTEPW-1:0]     dstep_q;
	logic                  ovf_q, zero_q;
	logic [PRODW:0]        rem_sh, rem_diff;

	logic [RATIOW-1:0]     ratio;
	logic [STW-1:0]        status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// loading
	assign abs_c    = current_sample[VW-1] ? MAGW'(-SVW'(current_sample)) : MAGW'(current_sample);
	assign store_we = cmd.load && (count_q < CNT_W'(MAX_POINTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			min_abs_q <= '0;
			vmin_q    <= '0;
		end else if (cmd.clear) begin
			count_q   <= '0;
			min_abs_q <= '0;
			vmin_q    <= '0;
		end else if (store_we) begin
			count_q <= count_q + CNT_W'(1);
			if (count_q == '0 || abs_c < min_abs_q) begin
				min_abs_q <= abs_c;
				vmin_q    <= voltage_sample;
			end
		end
	end

	ncs_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_voltage_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (voltage_sample),
		.raddr (idx_q),
		.rdata (rd_v)
	);

	ncs_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_current_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (current_sample),
		.raddr (idx_q),
		.rdata (rd_i)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + ADDR_W'(1);
		end
	end

	assign rv_ext   = SVW'(signed'(rd_v));
	assign rdv_diff = rv_ext - SVW'(cur_v_q);
	assign abs_rv   = rv_ext[SVW-1] ? MAGW'(-rv_ext) : MAGW'(rv_ext);
	assign abs_rdv  = rdv_diff[SVW-1] ? MAGW'(-rdv_diff) : MAGW'(rdv_diff);

	assign sts.keep     = (abs_rv >= MAGW'(tol_q)) && (abs_rdv >= MAGW'(tol_q));
	assign sts.idx_zero = (idx_q == '0);
	assign sts.idx_end  = (CNT_W'(idx_q) == count_q - CNT_W'(1));
	assign sts.div_last = (dstep_q == DSTEPW'(DIV_STEPS - 1));
	assign sts.out_busy = out_valid && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cur_v_q  <= signed'(rd_v);
			cur_i_q  <= signed'(rd_i);
			prev_v_q <= cur_v_q;
			prev_i_q <= cur_i_q;
		end
		if (cmd.mark) begin
			last_keep_q <= idx_q;
		end
	end

	// products: |dI|*|Vs| and |dV|*|I|
	assign dv     = SVW'(cur_v_q) - SVW'(prev_v_q);
	assign di     = SVW'(cur_i_q) - SVW'(prev_i_q);
	assign vs     = SVW'(cur_v_q) - SVW'(vmin_q);
	assign ci_ext = SVW'(cur_i_q);
	assign abs_dv = dv[SVW-1] ? MAGW'(-dv) : MAGW'(dv);
	assign abs_di = di[SVW-1] ? MAGW'(-di) : MAGW'(di);
	assign abs_vs = vs[SVW-1] ? MAGW'(-vs) : MAGW'(vs);
	assign abs_ci = ci_ext[SVW-1] ? MAGW'(-ci_ext) : MAGW'(ci_ext);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			num_q   <= PRODW'(abs_di) * PRODW'(abs_vs);
			den_q   <= PRODW'(abs_dv) * PRODW'(abs_ci);
			neg_q   <= (di[SVW-1] ^ vs[SVW-1]) ^ (dv[SVW-1] ^ ci_ext[SVW-1]);
			vs_q    <= vs;
			final_q <= (idx_q == last_keep_q);
		end
	end

	// restoring divide of num*2^16 by den; the top part of the dividend is
	// checked against den first, so only the low 33 quotient bits remain
	assign rem_sh   = {rem_q, dvd_q[DIV_STEPS-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dstep_q <= '0;
		end else if (cmd.div_init) begin
			dstep_q <= '0;
		end else if (cmd.div_step) begin
			dstep_q <= dstep_q + DSTEPW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q  <= PRODW'(num_q[PRODW-1:DIV_STEPS-FRACW]);
			dvd_q  <= {num_q[DIV_STEPS-FRACW-1:0], {FRACW{1'b0}}};
			quo_q  <= '0;
			ovf_q  <= PRODW'(num_q[PRODW-1:DIV_STEPS-FRACW]) >= den_q;
			zero_q <= (den_q == '0);
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DIV_STEPS-2:0], 1'b0};
			if (!rem_diff[PRODW]) begin
				rem_q <= rem_diff[PRODW-1:0];
				quo_q <= {quo_q[DIV_STEPS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[PRODW-1:0];
				quo_q <= {quo_q[DIV_STEPS-2:0], 1'b0};
			end
		end
	end

	// sign and saturation
	always_comb begin
		ratio  = '0;
		status = ST_OK;
		if (zero_q) begin
			status = ST_DIV0;
		end else if (ovf_q) begin
			status = ST_SAT;
			ratio  = neg_q ? {1'b1, {(RATIOW-1){1'b0}}} : {1'b0, {(RATIOW-1){1'b1}}};
		end else if (neg_q) begin
			if (quo_q > {2'b01, {(RATIOW-1){1'b0}}}) begin
				status = ST_SAT;
				ratio  = {1'b1, {(RATIOW-1){1'b0}}};
			end else begin
				ratio = RATIOW'(-quo_q);
			end
		end else begin
			if (quo_q[DIV_STEPS-1:RATIOW-1] != '0) begin
				status = ST_SAT;
				ratio  = {1'b0, {(RATIOW-1){1'b1}}};
			end else begin
				ratio = RATIOW'(quo_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			shifted_voltage   <= vs_q;
			conductance_ratio <= ratio;
			result_status     <= status;
			last_result       <= final_q;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && !out_ready))
		else $error("result register overwritten before it was taken");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond store depth");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> dstep_q < DSTEPW'(DIV_STEPS))
		else $error("divider stepped past its last quotient bit");

endmodule
`default_nettype wire

// ===== rtl/core/normalized_conductance_spectrum_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// normalized_conductance_spectrum_unit
// (dI/dV)/(I/V) spectrum of one I-V curve in signed Q16.16.
// ----------------------------------------------------------------------------
// Points are taken one per cycle and written to two MAX_POINTS-deep stores,
// tracking the voltage at the smallest absolute current. The point marked
// last starts processing and the block then takes no item until the curve is
// done: a keep scan reads and tests each stored point to find the final kept
// point, then a second pass reads and latches each point again and, for each
// kept point, runs a multiply, a divider set-up, 33 steps of the restoring
// divider and a result load, and the curve ends with a clear. The shared
// divider forms one quotient bit per cycle, for one kept point at a time.
// Results wait in an output register; a stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module normalized_conductance_spectrum_unit
	import ncs_pkg::*;
#(
	parameter int MAX_POINTS = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	ncs_sample_if.sink           sample_ch,
	ncs_result_if.source         result_ch,
	input  wire logic            cfg_we,
	input  wire logic [TOLW-1:0] cfg_wdata
);

	ncs_cmd_t cmd;
	ncs_sts_t sts;

	ncs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_ch.valid),
		.in_last  (sample_ch.last_point),
		.in_ready (sample_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ncs_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.voltage_sample    (sample_ch.voltage_sample),
		.current_sample    (sample_ch.current_sample),
		.out_valid         (result_ch.valid),
		.out_ready         (result_ch.ready),
		.shifted_voltage   (result_ch.shifted_voltage),
		.conductance_ratio (result_ch.conductance_ratio),
		.result_status     (result_ch.result_status),
		.last_result       (result_ch.last_result)
	);

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Checks normalized_conductance_spectrum_unit against a behavioural
// predictor. Curves are loaded over the sample channel and every result is
// compared field by field with the predicted spectrum point, under varied
// tolerance settings, bursty input and a stalling result channel.
// ----------------------------------------------------------------------------
module testbench
	import ncs_pkg::*;
();

	localparam int MAXP   = 64;
	localparam int SETTLE = 4 * MAXP + 40;  // trailing work after the final result
	localparam int HOLD_CYCLES = 400;

	localparam logic signed [VW-1:0] CODE_MIN = 24'sh800000;
	localparam logic signed [VW-1:0] CODE_MAX = 24'sh7FFFFF;
	localparam logic [TOLW-1:0]      TOL_MAX  = 23'h7FFFFF;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	typedef struct {
		logic signed [SVW-1:0] shifted;
		logic [RATIOW-1:0]     ratio;
		logic [STW-1:0]        status;
		logic                  last;
	} spectrum_point_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [TOLW-1:0] cfg_wdata;

	ncs_sample_if sample_ch();
	ncs_result_if result_ch();

	normalized_conductance_spectrum_unit #(.MAX_POINTS(MAXP)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state
	spectrum_point_t pending_results[$];
	logic [TOLW-1:0] tol_now = TOL_RESET;
	logic signed [VW-1:0] volt_mem[MAXP];
	logic signed [VW-1:0] curr_mem[MAXP];
	int pts_loaded = 0;
	logic [MAGW-1:0] min_mag = '0;
	logic signed [VW-1:0] v_at_min = '0;

	int mismatches = 0;
	int hold_requests = 0;
	int burst_left = 0;
	logic idle_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic longint unsigned magnitude(input longint x);
		return (x < 0) ? -x : x;
	endfunction

	// Load one point; on the marked point work out the whole spectrum.
	task automatic predict_point(input logic signed [VW-1:0] v, input logic signed [VW-1:0] c,
			input logic is_last);
		longint vi, dv, ci, di, vs;
		longint unsigned num, den, q;
		logic [RATIOW-1:0] r;
		logic [STW-1:0] st;
		logic neg;
		logic have_prev;
		spectrum_point_t held, e;
		have_prev = 1'b0;
		if (pts_loaded < MAXP) begin
			if (pts_loaded == 0 || magnitude(c) < min_mag) begin
				min_mag  = MAGW'(magnitude(c));
				v_at_min = v;
			end
			volt_mem[pts_loaded] = v;
			curr_mem[pts_loaded] = c;
			pts_loaded++;
		end
		if (!is_last)
			return;
		for (int i = 1; i < pts_loaded; i++) begin
			vi = volt_mem[i];
			dv = vi - volt_mem[i-1];
			ci = curr_mem[i];
			di = ci - curr_mem[i-1];
			if (magnitude(vi) < tol_now || magnitude(dv) < tol_now)
				continue;
			vs  = vi - v_at_min;
			den = magnitude(dv) * magnitude(ci);
			st  = ST_OK;
			if (den == 0) begin
				r  = '0;
				st = ST_DIV0;
			end else begin
				num = (magnitude(di) * magnitude(vs)) << FRACW;
				q   = num / den;
				neg = ((di < 0) != (vs < 0)) != ((dv < 0) != (ci < 0));
				if (q == 0) begin
					r = '0;
				end else if (neg) begin
					if (q > 64'h8000_0000) begin
						q  = 64'h8000_0000;
						st = ST_SAT;
					end
					r = RATIOW'(64'h1_0000_0000 - q);
				end else begin
					if (q > 64'h7FFF_FFFF) begin
						q  = 64'h7FFF_FFFF;
						st = ST_SAT;
					end
					r = RATIOW'(q);
				end
			end
			e.shifted = SVW'(vs);
			e.ratio   = r;
			e.status  = st;
			e.last    = 1'b0;
			// hold one back so the final point of the curve can be marked
			if (have_prev)
				pending_results.push_back(held);
			held = e;
			have_prev = 1'b1;
		end
		if (have_prev) begin
			held.last = 1'b1;
			pending_results.push_back(held);
		end
		pts_loaded = 0;
		min_mag    = '0;
		v_at_min   = '0;
	endtask

	task automatic send_point(input logic signed [VW-1:0] v, input logic signed [VW-1:0] c,
			input logic is_last);
		int gap;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = idle_on ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				@(negedge clk);
				sample_ch.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		sample_ch.valid          = 1'b1;
		sample_ch.voltage_sample = v;
		sample_ch.current_sample = c;
		sample_ch.last_point     = is_last;
		do @(posedge clk); while (!sample_ch.ready);
		predict_point(v, c, is_last);
	endtask

	task automatic stop_sending;
		@(negedge clk);
		sample_ch.valid = 1'b0;
	endtask

	task automatic wait_drained;
		stop_sending();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_tolerance(input logic [TOLW-1:0] tol);
		wait_drained();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = tol;
		@(negedge clk);
		cfg_we    = 1'b0;
		tol_now   = tol;
	endtask

	function automatic logic signed [VW-1:0] pick_code();
		case ($urandom_range(0, 9))
			0: return CODE_MIN;
			1: return CODE_MAX;
			2: return '0;
			3, 4: return VW'(int'($urandom_range(0, 256)) - 128);
			default: return VW'($urandom);
		endcase
	endfunction

	// Mostly sweeps with random steps; some repeated or near-zero voltages.
	task automatic send_random_curve(input int len);
		logic signed [VW-1:0] v, step;
		v = pick_code();
		step = $urandom_range(0, 1) ? VW'($urandom_range(1, 600)) : VW'($urandom);
		if ($urandom_range(0, 1))
			step = -step;
		for (int k = 0; k < len; k++) begin
			if (k > 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: v = v + step;
					6: ;
					7: v = VW'(int'($urandom_range(0, 16)) - 8);
					default: v = pick_code();
				endcase
			end
			send_point(v, pick_code(), k == len - 1);
		end
	endtask

	task automatic test_basic;
		send_point(24'sd1234, 24'sd55, 1'b1);       // lone point: no result
		send_point(24'sd100, 24'sd200, 1'b0);
		send_point(24'sd300, 24'sd500, 1'b0);
		send_point(-24'sd400, -24'sd900, 1'b1);
		send_point(24'sd50, 24'sd100, 1'b0);        // kept point is the minimum: Vs = 0
		send_point(24'sd60, 24'sd2, 1'b1);
		send_point(24'sd5, 24'sd7, 1'b0);           // zero current divisor
		send_point(24'sd9, 24'sd0, 1'b1);
		send_point(-24'sd5, 24'sd3, 1'b0);          // near-zero and repeated voltages
		send_point(24'sd0, 24'sd4, 1'b0);
		send_point(-24'sd5, 24'sd2, 1'b0);
		send_point(-24'sd5, 24'sd6, 1'b1);
	endtask

	// Full-scale codes, with clamping in both directions
	task automatic test_extremes;
		send_point(CODE_MIN, 24'sd0, 1'b0);
		send_point(24'sd8388600, 24'sd1000, 1'b0);
		send_point(24'sd8388601, CODE_MIN, 1'b0);
		send_point(CODE_MAX, CODE_MAX, 1'b0);
		send_point(-24'sd100, -24'sd3, 1'b1);
	endtask

	task automatic test_zero_tolerance;
		set_tolerance('0);
		send_point(24'sd0, 24'sd5, 1'b0);
		send_point(24'sd0, 24'sd3, 1'b0);           // dV of zero
		send_point(24'sd7, 24'sd0, 1'b0);
		send_point(-24'sd7, -24'sd4, 1'b1);
	endtask

	task automatic test_max_tolerance;
		set_tolerance(TOL_MAX);
		send_point(CODE_MAX, 24'sd1, 1'b0);
		send_point(CODE_MIN, 24'sd2, 1'b0);
		send_point(24'sd0, 24'sd9, 1'b1);
	endtask

	// The two points past the store, both with zero current, are dropped.
	task automatic test_full_store;
		set_tolerance(23'd1);
		idle_on = 1'b1;
		for (int k = 0; k < MAXP + 2; k++) begin
			if (k < MAXP)
				send_point(VW'(-40000 + k * 1201), pick_code(), 1'b0);
			else
				send_point(VW'($urandom), 24'sd0, k == MAXP + 1);
		end
	endtask

	task automatic test_backpressure;
		wait_drained();
		hold_requests++;
		idle_on = 1'b0;
		for (int k = 0; k < 6; k++)
			send_point(VW'(-3000 + k * 1000), VW'($urandom_range(1, 90000)), k == 5);
		for (int k = 0; k < 5; k++)
			send_point(VW'(500 - k * 77), pick_code(), k == 4);
		idle_on = 1'b1;
		wait_drained();
		send_random_curve(4);
	endtask

	task automatic test_random_phase(input logic [TOLW-1:0] tol, input int n_items);
		int sent, len, r;
		set_tolerance(tol);
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 19);
			if (r < 2)
				len = 1;
			else if (r == 2)
				len = $urandom_range(10, 24);
			else
				len = $urandom_range(2, 8);
			idle_on = ($urandom_range(0, 3) != 0);
			send_random_curve(len);
			sent += len;
		end
	endtask

	initial begin
		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_wdata                = '0;
		sample_ch.valid          = 1'b0;
		sample_ch.voltage_sample = '0;
		sample_ch.current_sample = '0;
		sample_ch.last_point     = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic();
		test_extremes();
		test_zero_tolerance();
		test_max_tolerance();
		test_full_store();
		test_backpressure();
		test_random_phase(23'd1, 15);
		test_random_phase('0, 8);
		test_random_phase(TOLW'($urandom_range(2, 2000)), 10);
		test_random_phase(TOLW'($urandom_range(1 << 20, 8388606)), 5);
		test_random_phase(TOL_MAX, 5);

		wait_drained();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// result side: stall pattern changes every so often; long hold on request
	initial begin : result_stall
		rx_mode_t mode;
		int span, tick, hold_left, holds_seen;
		result_ch.ready = 1'b0;
		mode = RX_OPEN;
		span = 0;
		tick = 0;
		hold_left = 0;
		holds_seen = 0;
		forever begin
			@(negedge clk);
			if (holds_seen != hold_requests) begin
				holds_seen = hold_requests;
				hold_left  = HOLD_CYCLES;
			end
			if (span == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				span = $urandom_range(20, 120);
			end
			span--;
			tick++;
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready = 1'b0;
			end else begin
				case (mode)
					RX_OPEN:   result_ch.ready = 1'b1;
					RX_COIN:   result_ch.ready = 1'($urandom_range(0, 1));
					RX_SPARSE: result_ch.ready = ($urandom_range(0, 3) != 0);
					default:   result_ch.ready = (tick % 7 >= 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		spectrum_point_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: Vs %0d ratio %h status %0d last %b",
						result_ch.shifted_voltage, result_ch.conductance_ratio,
						result_ch.result_status, result_ch.last_result);
			end else begin
				want = pending_results.pop_front();
				if (result_ch.shifted_voltage !== want.shifted ||
						result_ch.conductance_ratio !== want.ratio ||
						result_ch.result_status !== want.status ||
						result_ch.last_result !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: Vs %0d/%0d ratio %h/%h status %0d/%0d last %b/%b (exp/got)",
							want.shifted, result_ch.shifted_voltage,
							want.ratio, result_ch.conductance_ratio,
							want.status, result_ch.result_status,
							want.last, result_ch.last_result);
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== normalized_conductance_spectrum_unit.f =====
rtl/core/ncs_pkg.sv
rtl/core/ncs_if.sv
rtl/core/ncs_ram.sv
rtl/core/ncs_ctrl.sv
rtl/core/ncs_dp.sv
rtl/core/normalized_conductance_spectrum_unit.sv
bench/testbench.sv
